/* rtl/wfe_pkg.sv */
// Shared types, constants and elaboration-time table builders for the Weierstrass fitness unit.
package wfe_pkg;

	localparam int COORD_W      = 25;
	localparam int FRAC_W       = 24;
	localparam int COS_BITS     = 10;
	localparam int QTR_BITS     = COS_BITS - 2;
	localparam int QTAB_N       = 1 << QTR_BITS;
	localparam int ENT_W        = 17;
	localparam int TERM_W       = ENT_W + 1;
	localparam int FIT_W        = 30;
	localparam int BIAS_W       = 11;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 32;
	localparam int DEF_MAX_DIM  = 1024;
	localparam int DEF_MAX_TERM = 20;

	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	typedef struct packed {
		logic valid;
		logic last;
		logic counted;
	} wfe_ctl_t;

	typedef logic [QTAB_N-1:0][ENT_W-1:0] qcos_tab_t;

	function automatic logic [63:0] poly_cos(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] h;
		x2 = (x * x) >> 30;
		h = Q30_ONE;
		h = Q30_ONE - (((x2 * h) >> 30) / 132);
		h = Q30_ONE - (((x2 * h) >> 30) / 90);
		h = Q30_ONE - (((x2 * h) >> 30) / 56);
		h = Q30_ONE - (((x2 * h) >> 30) / 30);
		h = Q30_ONE - (((x2 * h) >> 30) / 12);
		h = Q30_ONE - (((x2 * h) >> 30) / 2);
		return h;
	endfunction

	function automatic logic [63:0] poly_sin(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] h;
		x2 = (x * x) >> 30;
		h = Q30_ONE;
		h = Q30_ONE - (((x2 * h) >> 30) / 110);
		h = Q30_ONE - (((x2 * h) >> 30) / 72);
		h = Q30_ONE - (((x2 * h) >> 30) / 42);
		h = Q30_ONE - (((x2 * h) >> 30) / 20);
		h = Q30_ONE - (((x2 * h) >> 30) / 6);
		return (x * h) >> 30;
	endfunction

	function automatic logic [63:0] table_angle(input logic [63:0] r);
		return (r * TWO_PI_Q30 + (64'd1 << (COS_BITS - 1))) >> COS_BITS;
	endfunction

	// Cosine of r table steps within the first quarter turn, rounded to Q.16.
	function automatic logic [63:0] quarter_cos(input logic [63:0] r);
		logic [63:0] v;
		logic [63:0] qtr;
		qtr = 64'(QTAB_N);
		if (r * 2 <= qtr) begin
			v = poly_cos(table_angle(r));
		end else begin
			v = poly_sin(table_angle(qtr - r));
		end
		return (v + 64'd8192) >> 14;
	endfunction

	function automatic qcos_tab_t build_qcos();
		qcos_tab_t tab;
		for (int r = 0; r < QTAB_N; r++) begin
			tab[r] = ENT_W'(quarter_cos(64'(r)));
		end
		return tab;
	endfunction

	localparam qcos_tab_t QCOS_TAB = build_qcos();

	// 3^k reduced to the phase width.
	function automatic logic [FRAC_W-1:0] pow3_mod(input int k);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++) begin
			p = (p * 3) & ((64'd1 << FRAC_W) - 1);
		end
		return FRAC_W'(p);
	endfunction

	// Sum of the weighted unit terms: the Q.16 form of 2 - 2^-kmax.
	function automatic logic [63:0] unit_offset(input int kmax);
		logic [63:0] w;
		w = 64'd0;
		for (int k = 0; k <= kmax; k++) begin
			w = w + ((64'd65536 + ((64'd1 << k) >> 1)) >> k);
		end
		return w;
	endfunction

endpackage

/* rtl/wfe_lane.sv */
// One Weierstrass term: phase from 3^k times t, cosine lookup and 2^-k weighting.
module wfe_lane import wfe_pkg::*; #(
	parameter int K = 0
) (
	input  logic              clk,
	input  logic              en,
	input  logic [FRAC_W-1:0] t_s1,
	output logic [TERM_W-1:0] term_s3
);

	localparam logic [FRAC_W-1:0] P3    = pow3_mod(K);
	localparam logic [FRAC_W-1:0] ROUND = FRAC_W'(1) << (FRAC_W - COS_BITS - 1);
	localparam logic [31:0]       HALF  = 32'((64'd1 << K) >> 1);

	logic [FRAC_W-1:0]   phase;
	logic [FRAC_W-1:0]   phase_rnd;
	logic [COS_BITS-1:0] idx_s2;
	logic [1:0]          qd;
	logic [QTR_BITS:0]   rr;
	logic [ENT_W-1:0]    mag;
	logic [31:0]         mag_rnd;
	logic [ENT_W-1:0]    mag_w;
	logic                neg;
	logic [TERM_W-1:0]   term;

	// The product is taken modulo the phase width, which is exactly frac(3^k * t).
	assign phase     = t_s1 * P3;
	assign phase_rnd = phase + ROUND;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2 <= phase_rnd[FRAC_W-1 -: COS_BITS];
		end
	end

	// Quarter-wave symmetry: odd quadrants read the mirrored entry.
	assign qd  = idx_s2[COS_BITS-1 -: 2];
	assign rr  = qd[0] ? ((QTR_BITS+1)'(QTAB_N) - {1'b0, idx_s2[QTR_BITS-1:0]})
	                   : {1'b0, idx_s2[QTR_BITS-1:0]};
	assign mag = rr[QTR_BITS] ? '0 : QCOS_TAB[rr[QTR_BITS-1:0]];
	assign neg = qd[1] ^ qd[0];

	assign mag_rnd = 32'(mag) + HALF;
	assign mag_w   = ENT_W'(mag_rnd >> K);
	assign term    = neg ? (TERM_W'(0) - {1'b0, mag_w}) : {1'b0, mag_w};

	always_ff @(posedge clk) begin
		if (en) begin
			term_s3 <= term;
		end
	end

endmodule

/* rtl/wfe_sum.sv */
// Registered adder tree over the lane terms, with the per-coordinate offset folded in.
module wfe_sum import wfe_pkg::*; #(
	parameter int MAX_TERM_INDEX = DEF_MAX_TERM
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  wfe_ctl_t                             ctl_s3,
	input  logic [MAX_TERM_INDEX:0][TERM_W-1:0]  term_s3,
	output wfe_ctl_t                             ctl_s5,
	output logic [FIT_W-1:0]                     delta_s5
);

	localparam int NLANE  = MAX_TERM_INDEX + 1;
	localparam int NGRP   = (NLANE + 3) / 4;
	localparam int PART_W = TERM_W + 2;
	localparam int TOT_W  = PART_W + $clog2(NGRP) + 1;
	localparam logic [FIT_W-1:0] UNIT_W = FIT_W'(unit_offset(MAX_TERM_INDEX));

	wfe_ctl_t                       ctl_s4;
	logic [NGRP-1:0][PART_W-1:0]    part_d;
	logic [NGRP-1:0][PART_W-1:0]    part_s4;
	logic [TOT_W-1:0]               total;
	logic [FIT_W-1:0]               delta_d;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			part_d[g] = '0;
			for (int j = 0; j < 4; j++) begin
				if (4 * g + j < NLANE) begin
					part_d[g] = part_d[g] + PART_W'($signed(term_s3[4 * g + j]));
				end
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total + TOT_W'($signed(part_s4[g]));
		end
	end

	// Coordinates beyond the dimension limit contribute nothing.
	assign delta_d = ctl_s4.counted ? (FIT_W'($signed(total)) + UNIT_W) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s4  <= part_d;
			delta_s5 <= delta_d;
		end
	end

endmodule

/* rtl/wfe_acc.sv */
// Running fitness accumulator with a two-entry result buffer on the output stream.
module wfe_acc import wfe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  wfe_ctl_t               ctl_s5,
	input  logic [FIT_W-1:0]       delta_s5,
	input  logic [BIAS_W-1:0]      bias,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic [FIT_W-1:0]       fitness,
	output logic                   stall
);

	logic [FIT_W-1:0] sum_q;
	logic [FIT_W-1:0] sum_next;
	logic [FIT_W-1:0] bias_q16;
	logic [FIT_W-1:0] res;
	logic             push;
	logic             pop;
	logic             out_v_q;
	logic             skid_v_q;
	logic [FIT_W-1:0] out_q;
	logic [FIT_W-1:0] skid_q;

	assign sum_next = sum_q + delta_s5;
	assign bias_q16 = FIT_W'($signed(bias)) << 16;
	assign res      = sum_next + bias_q16;
	assign push     = en && ctl_s5.valid && ctl_s5.last;
	assign pop      = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en && ctl_s5.valid) begin
				sum_q <= ctl_s5.last ? '0 : sum_next;
			end
			// A push only happens with the skid entry empty.
			if (push) begin
				if (!out_v_q || pop) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_v_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (pop && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign fitness  = out_q;
	assign stall    = skid_v_q;

endmodule

/* rtl/weierstrass_fitness_eval_unit.sv */
// Top level of the Weierstrass benchmark fitness evaluator.
//
// This unit evaluates the Weierstrass objective over a vector that arrives one
// coordinate per request on the slave stream, the last coordinate flagged with
// tlast. It takes one coordinate every clock cycle while the pipeline is not
// paused: all kmax+1 terms are worked out side by side in their own lanes, and
// the pipeline is input register, phase multiply, cosine lookup with weighting,
// two levels of adder tree and the accumulator, which registers each finished
// result into the output buffer. A two-entry result buffer sits on
// the master stream, so the unit keeps taking coordinates while one result
// waits; only when a second result is ready behind an untaken one does the
// whole pipeline pause. Coordinates past the MAX_DIM-th of a vector are ignored
// but a last mark on them still produces the result and starts a new vector.
// The bias register is written over the configuration channel, which is always
// ready, and must only be changed while no vector is in flight.
module weierstrass_fitness_eval_unit import wfe_pkg::*; #(
	parameter int MAX_DIM        = DEF_MAX_DIM,
	parameter int MAX_TERM_INDEX = DEF_MAX_TERM
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration: cfg_data is bias (11 bits, signed).
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [BIAS_W-1:0]      cfg_data,
	// tdata bits [24:0] coord (signed, 24 fraction bits), [31:25] zero.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tlast,
	// tdata bits [29:0] fitness (signed Q.16), [31:30] zero.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int NLANE = MAX_TERM_INDEX + 1;
	localparam int CNT_W = $clog2(MAX_DIM + 1);

	logic                            en;
	logic                            stall;
	logic                            accept;
	logic                            counted;
	logic [CNT_W-1:0]                cnt_q;
	logic [BIAS_W-1:0]               bias_q;
	logic [FRAC_W-1:0]               t_s1;
	wfe_ctl_t                        ctl_s1;
	wfe_ctl_t                        ctl_s2;
	wfe_ctl_t                        ctl_s3;
	wfe_ctl_t                        ctl_s5;
	logic [NLANE-1:0][TERM_W-1:0]    term_s3;
	logic [FIT_W-1:0]                delta_s5;
	logic [FIT_W-1:0]                fitness;

	// The whole pipeline moves together unless the result buffer is full.
	assign en            = !stall;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign counted       = cnt_q < CNT_W'(MAX_DIM);
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			bias_q <= cfg_data;
		end
	end

	// Coordinate count of the vector in progress, cleared by the last request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				cnt_q <= '0;
			end else if (counted) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: s_axis_tvalid, last: s_axis_tlast, counted: counted};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Adding one half modulo one only flips the top fraction bit.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= {~s_axis_tdata[FRAC_W-1], s_axis_tdata[FRAC_W-2:0]};
		end
	end

	for (genvar k = 0; k < NLANE; k++) begin : g_lane
		wfe_lane #(
			.K (k)
		) u_lane (
			.clk     (clk),
			.en      (en),
			.t_s1    (t_s1),
			.term_s3 (term_s3[k])
		);
	end

	wfe_sum #(
		.MAX_TERM_INDEX (MAX_TERM_INDEX)
	) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s3   (ctl_s3),
		.term_s3  (term_s3),
		.ctl_s5   (ctl_s5),
		.delta_s5 (delta_s5)
	);

	wfe_acc u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s5   (ctl_s5),
		.delta_s5 (delta_s5),
		.bias     (bias_q),
		.m_tready (m_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.fitness  (fitness),
		.stall    (stall)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - FIT_W)'(0), fitness};

endmodule

/* rtl/wfe_checker.sv */
// Port-level checks for the Weierstrass fitness unit, bound to the top level.
module wfe_checker import wfe_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or vanished while stalled");

	// With no result pending the input side must be open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result buffer");

	// Input back-pressure only follows a result that was refused.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a refused result");

	// The padding above the fitness field stays zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:FIT_W] == '0)
		else $error("non-zero padding on result data");

endmodule

bind weierstrass_fitness_eval_unit wfe_checker u_wfe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
